// ===== design/wsfp_pkg.sv =====
// shared types and phase codes for the websocket frame parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wsfp_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned OP_W   = 4;
	localparam int unsigned LEN_W  = 64;
	localparam int unsigned KEY_W  = 32;

	// parse phase codes
	localparam logic [2:0] PH_HDR   = 3'd0;
	localparam logic [2:0] PH_LEN   = 3'd1;
	localparam logic [2:0] PH_LEN16 = 3'd2;
	localparam logic [2:0] PH_LEN64 = 3'd3;
	localparam logic [2:0] PH_KEY   = 3'd4;
	localparam logic [2:0] PH_DATA  = 3'd5;

	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;
	localparam logic [3:0] LEN16_BYTES = 4'd2;
	localparam logic [3:0] LEN64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              valid;
		logic              last;
		logic              fin;
		logic [OP_W-1:0]   opcode;
		logic              err;
	} wsfp_res_t;

endpackage

`default_nettype wire

// ===== design/websocket_frame_parser.sv =====
// top level of the websocket frame parser
// depends on wsfp_pkg, wsfp_in_stage, wsfp_core, wsfp_out_reg
`timescale 1ns / 1ps
`default_nettype none

// Parses a WebSocket frame stream (RFC 6455 framing) one byte per item and delivers
// unmasked payload bytes. Each accepted byte is held in an input register, decoded
// combinationally against the parse state, and any item it yields lands in an output
// register, so the block sustains one byte per clock while out_ready is high; a byte
// waits in the input register while the output register is stalled. Header bytes give no
// item, except the last header byte of a zero-length frame, which gives an item with
// frame_end set and payload_valid clear, and a rejected header byte. A FIN/opcode
// mismatch in a header sets protocol_error on that and every later item until reset;
// RSV bits are ignored and every frame, final or not, is followed by a new header.
module websocket_frame_parser (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            payload_valid,
	output logic            frame_end,
	output logic            final_fragment,
	output logic [3:0]      frame_opcode,
	output logic            protocol_error
);

	logic                        valid_s1;
	logic [wsfp_pkg::BYTE_W-1:0] byte_s1;
	logic                        slot_free;
	logic                        step;
	logic                        res_vld;
	wsfp_pkg::wsfp_res_t         res;
	wsfp_pkg::wsfp_res_t         res_q;

	// a held byte is decoded only when its item, if any, has a place to go
	assign step = valid_s1 && slot_free;

	wsfp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.take     (step),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	wsfp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_s1 (byte_s1),
		.res_vld (res_vld),
		.res     (res)
	);

	wsfp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && res_vld),
		.res       (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.slot_free (slot_free),
		.res_q     (res_q)
	);

	assign out_byte       = res_q.data;
	assign payload_valid  = res_q.valid;
	assign frame_end      = res_q.last;
	assign final_fragment = res_q.fin;
	assign frame_opcode   = res_q.opcode;
	assign protocol_error = res_q.err;

endmodule

`default_nettype wire

// ===== design/wsfp_in_stage.sv =====
// input register of the frame parser: holds one received byte
// depends on wsfp_pkg
`timescale 1ns / 1ps
`default_nettype none

module wsfp_in_stage (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [wsfp_pkg::BYTE_W-1:0] in_byte,
	input  wire logic                       take,
	output logic                            valid_s1,
	output logic [wsfp_pkg::BYTE_W-1:0]     byte_s1
);

	// the held item leaves when the parser takes it, so a new one can enter the same cycle
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

`default_nettype wire

// ===== design/wsfp_core.sv =====
// frame parse state and per-byte decode: header, length, key, payload unmasking
// depends on wsfp_pkg
`timescale 1ns / 1ps
`default_nettype none

module wsfp_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [wsfp_pkg::BYTE_W-1:0] byte_s1,
	output logic                             res_vld,
	output wsfp_pkg::wsfp_res_t              res
);

	logic [2:0]                  phase_q, phase_n;
	logic                        fin_q, fin_n;
	logic [wsfp_pkg::OP_W-1:0]   op_q, op_n;
	logic                        mask_q, mask_n;
	logic [wsfp_pkg::LEN_W-1:0]  left_q, left_n;
	logic [3:0]                  hc_q, hc_n;
	logic [wsfp_pkg::KEY_W-1:0]  key_q, key_n;
	logic [1:0]                  kpos_q, kpos_n;
	logic                        halted_q, halted_n;

	logic                        len_done;
	logic                        go_pay;
	logic [6:0]                  len_code;
	logic [wsfp_pkg::BYTE_W-1:0] key_b;

	always_comb begin
		phase_n  = phase_q;
		fin_n    = fin_q;
		op_n     = op_q;
		mask_n   = mask_q;
		left_n   = left_q;
		hc_n     = hc_q;
		key_n    = key_q;
		kpos_n   = kpos_q;
		halted_n = halted_q;
		len_done = 1'b0;
		go_pay   = 1'b0;
		res_vld  = 1'b0;
		res.data  = '0;
		res.valid = 1'b0;
		res.last  = 1'b0;
		res.err   = 1'b0;
		len_code = byte_s1[6:0];
		case (kpos_q)
			2'd0: key_b = key_q[31:24];
			2'd1: key_b = key_q[23:16];
			2'd2: key_b = key_q[15:8];
			default: key_b = key_q[7:0];
		endcase

		if (halted_q) begin
			res_vld = 1'b1;
			res.err = 1'b1;
		end else begin
			case (phase_q)
				wsfp_pkg::PH_LEN: begin
					mask_n = byte_s1[7];
					hc_n   = '0;
					left_n = '0;
					if (len_code == wsfp_pkg::LEN_CODE_16) begin
						phase_n = wsfp_pkg::PH_LEN16;
					end else if (len_code == wsfp_pkg::LEN_CODE_64) begin
						phase_n = wsfp_pkg::PH_LEN64;
					end else begin
						left_n   = {{(wsfp_pkg::LEN_W-7){1'b0}}, len_code};
						len_done = 1'b1;
					end
				end
				wsfp_pkg::PH_LEN16, wsfp_pkg::PH_LEN64: begin
					// extended length arrives big-endian
					left_n = {left_q[wsfp_pkg::LEN_W-9:0], byte_s1};
					hc_n   = hc_q + 4'd1;
					if (hc_n >= ((phase_q == wsfp_pkg::PH_LEN16) ?
							wsfp_pkg::LEN16_BYTES : wsfp_pkg::LEN64_BYTES)) begin
						len_done = 1'b1;
					end
				end
				wsfp_pkg::PH_KEY: begin
					key_n = {key_q[wsfp_pkg::KEY_W-9:0], byte_s1};
					hc_n  = hc_q + 4'd1;
					if (hc_n >= wsfp_pkg::KEY_BYTES) begin
						hc_n   = '0;
						go_pay = 1'b1;
					end
				end
				wsfp_pkg::PH_DATA: begin
					res_vld   = 1'b1;
					res.valid = 1'b1;
					res.data  = mask_q ? (byte_s1 ^ key_b) : byte_s1;
					kpos_n    = kpos_q + 2'd1;
					left_n    = left_q - 64'd1;
					if (left_n == '0) begin
						phase_n  = wsfp_pkg::PH_HDR;
						res.last = 1'b1;
					end
				end
				default: begin
					fin_n = byte_s1[7];
					op_n  = byte_s1[3:0];
					// a header is rejected on fin with opcode 0, or on no fin with a nonzero opcode
					if ((fin_n && op_n == '0) || (!fin_n && op_n != '0)) begin
						halted_n = 1'b1;
						res_vld  = 1'b1;
						res.err  = 1'b1;
					end else begin
						phase_n = wsfp_pkg::PH_LEN;
					end
				end
			endcase

			if (len_done) begin
				hc_n = '0;
				if (mask_n) begin
					key_n   = '0;
					phase_n = wsfp_pkg::PH_KEY;
				end else begin
					go_pay = 1'b1;
				end
			end

			if (go_pay) begin
				kpos_n = '0;
				if (left_n == '0) begin
					// zero-length frame ends on its last header byte
					phase_n  = wsfp_pkg::PH_HDR;
					res_vld  = 1'b1;
					res.last = 1'b1;
				end else begin
					phase_n = wsfp_pkg::PH_DATA;
				end
			end
		end

		res.fin    = fin_n;
		res.opcode = op_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wsfp_pkg::PH_HDR;
			fin_q    <= 1'b1;
			op_q     <= '0;
			mask_q   <= 1'b0;
			left_q   <= '0;
			hc_q     <= '0;
			key_q    <= '0;
			kpos_q   <= '0;
			halted_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_n;
			fin_q    <= fin_n;
			op_q     <= op_n;
			mask_q   <= mask_n;
			left_q   <= left_n;
			hc_q     <= hc_n;
			key_q    <= key_n;
			kpos_q   <= kpos_n;
			halted_q <= halted_n;
		end
	end

endmodule

`default_nettype wire

// ===== design/wsfp_out_reg.sv =====
// result register of the frame parser: holds one finished item for the consumer
// depends on wsfp_pkg
`timescale 1ns / 1ps
`default_nettype none

module wsfp_out_reg (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire wsfp_pkg::wsfp_res_t res,
	input  wire logic                out_ready,
	output logic                     out_valid,
	output logic                     slot_free,
	output wsfp_pkg::wsfp_res_t      res_q
);

	assign slot_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== tb/tb_websocket_frame_parser.sv =====
// self-checking testbench for websocket_frame_parser: directed and random frame streams
// with random idling on both channels, every item checked against a behavioral decoder
// depends on wsfp_pkg and websocket_frame_parser
`timescale 1ns / 1ps

module tb_websocket_frame_parser;

	typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 6;
	localparam int REPORT_LIMIT = 10;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       payload_valid;
	logic       frame_end;
	logic       final_fragment;
	logic [3:0] frame_opcode;
	logic       protocol_error;

	logic [7:0]          stream_bytes[$];
	wsfp_pkg::wsfp_res_t expected_results[$];
	int         bytes_queued = 0;
	int         mismatch_count = 0;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	bit         in_taken = 1'b0;
	bit         hold_req = 1'b0;
	bit         hold_done = 1'b0;
	int         hold_count = 0;

	// decoder state
	logic [2:0]  ws_phase = wsfp_pkg::PH_HDR;
	logic        ws_fin = 1'b1;
	logic [3:0]  ws_op = 4'h0;
	logic        ws_mask = 1'b0;
	logic [63:0] ws_left = 64'd0;
	logic [3:0]  ws_hcount = 4'd0;
	logic [31:0] ws_key = 32'd0;
	logic [1:0]  ws_key_pos = 2'd0;
	logic        ws_halted = 1'b0;

	websocket_frame_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.payload_valid(payload_valid),
		.frame_end(frame_end),
		.final_fragment(final_fragment),
		.frame_opcode(frame_opcode),
		.protocol_error(protocol_error)
	);

	always #1 clk = ~clk;

	function automatic wsfp_pkg::wsfp_res_t result_of(logic [7:0] data, logic valid,
			logic last, logic err);
		wsfp_pkg::wsfp_res_t r;
		r.data = data;
		r.valid = valid;
		r.last = last;
		r.fin = ws_fin;
		r.opcode = ws_op;
		r.err = err;
		return r;
	endfunction

	task automatic start_payload(output bit produced, output wsfp_pkg::wsfp_res_t res);
		produced = 1'b0;
		res = '0;
		ws_key_pos = 2'd0;
		if (ws_left == 64'd0) begin
			// empty frame ends on its last header byte
			ws_phase = wsfp_pkg::PH_HDR;
			produced = 1'b1;
			res = result_of(8'h00, 1'b0, 1'b1, 1'b0);
		end else begin
			ws_phase = wsfp_pkg::PH_DATA;
		end
	endtask

	task automatic length_done(output bit produced, output wsfp_pkg::wsfp_res_t res);
		produced = 1'b0;
		res = '0;
		ws_hcount = 4'd0;
		if (ws_mask) begin
			ws_key = 32'd0;
			ws_phase = wsfp_pkg::PH_KEY;
		end else begin
			start_payload(produced, res);
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, output bit produced,
			output wsfp_pkg::wsfp_res_t res);
		logic [6:0] len_code;
		logic [7:0] data;
		produced = 1'b0;
		res = '0;
		if (ws_halted) begin
			produced = 1'b1;
			res = result_of(8'h00, 1'b0, 1'b0, 1'b1);
			return;
		end
		case (ws_phase)
		wsfp_pkg::PH_LEN: begin
			ws_mask = b[7];
			len_code = b[6:0];
			ws_hcount = 4'd0;
			ws_left = 64'd0;
			if (len_code < wsfp_pkg::LEN_CODE_16) begin
				ws_left = {57'd0, len_code};
				length_done(produced, res);
			end else if (len_code == wsfp_pkg::LEN_CODE_16) begin
				ws_phase = wsfp_pkg::PH_LEN16;
			end else begin
				ws_phase = wsfp_pkg::PH_LEN64;
			end
		end
		wsfp_pkg::PH_LEN16, wsfp_pkg::PH_LEN64: begin
			ws_left = {ws_left[55:0], b};
			ws_hcount = ws_hcount + 4'd1;
			if (ws_hcount >= ((ws_phase == wsfp_pkg::PH_LEN16) ?
					wsfp_pkg::LEN16_BYTES : wsfp_pkg::LEN64_BYTES))
				length_done(produced, res);
		end
		wsfp_pkg::PH_KEY: begin
			ws_key = {ws_key[23:0], b};
			ws_hcount = ws_hcount + 4'd1;
			if (ws_hcount >= wsfp_pkg::KEY_BYTES) begin
				ws_hcount = 4'd0;
				start_payload(produced, res);
			end
		end
		wsfp_pkg::PH_DATA: begin
			data = b;
			if (ws_mask)
				data = b ^ ws_key[8 * (3 - int'(ws_key_pos)) +: 8];
			ws_key_pos = ws_key_pos + 2'd1;
			ws_left = ws_left - 64'd1;
			produced = 1'b1;
			if (ws_left == 64'd0) begin
				ws_phase = wsfp_pkg::PH_HDR;
				res = result_of(data, 1'b1, 1'b1, 1'b0);
			end else begin
				res = result_of(data, 1'b1, 1'b0, 1'b0);
			end
		end
		default: begin
			ws_fin = b[7];
			ws_op = b[3:0];
			if ((ws_fin && ws_op == 4'h0) || (!ws_fin && ws_op != 4'h0)) begin
				ws_halted = 1'b1;
				produced = 1'b1;
				res = result_of(8'h00, 1'b0, 1'b0, 1'b1);
			end else begin
				ws_phase = wsfp_pkg::PH_LEN;
			end
		end
		endcase
	endtask

	task automatic push_byte(input logic [7:0] b);
		stream_bytes.insert(stream_bytes.size(), b);
		bytes_queued++;
	endtask

	// fill < 0 gives random payload, otherwise every payload byte is fill
	task automatic queue_frame(input bit fin, input logic [2:0] rsv, input logic [3:0] op,
			input bit masked, input len_form_t form, input longint unsigned len,
			input logic [31:0] key, input int fill);
		logic [63:0] len_bits;
		len_bits = len;
		push_byte({fin, rsv, op});
		case (form)
		LEN_SHORT: begin
			push_byte({masked, len_bits[6:0]});
		end
		LEN_EXT16: begin
			push_byte({masked, wsfp_pkg::LEN_CODE_16});
			push_byte(len_bits[15:8]);
			push_byte(len_bits[7:0]);
		end
		default: begin
			push_byte({masked, wsfp_pkg::LEN_CODE_64});
			for (int i = 7; i >= 0; i--)
				push_byte(len_bits[8 * i +: 8]);
		end
		endcase
		if (masked)
			for (int i = 3; i >= 0; i--)
				push_byte(key[8 * i +: 8]);
		for (longint unsigned n = 0; n < len; n++)
			push_byte((fill < 0) ? 8'($urandom) : 8'(fill));
	endtask

	task automatic queue_random_frames(input int target);
		int start;
		bit fin;
		logic [3:0] op;
		len_form_t form;
		longint unsigned len;
		int pick;
		start = bytes_queued;
		while (bytes_queued - start < target) begin
			// only legal fin/opcode pairs here, a bad header would halt the parser
			fin = ($urandom_range(3) != 0);
			op = fin ? 4'($urandom_range(15, 1)) : 4'h0;
			pick = $urandom_range(99);
			form = LEN_SHORT;
			if (pick < 12) begin
				len = 0;
			end else if (pick < 76) begin
				len = $urandom_range(12, 1);
			end else if (pick < 81) begin
				len = $urandom_range(125, 13);
			end else if (pick < 89) begin
				form = LEN_EXT16;
				len = $urandom_range(40);
			end else if (pick < 90) begin
				form = LEN_EXT16;
				len = $urandom_range(300, 256);
			end else begin
				form = LEN_EXT64;
				len = $urandom_range(40);
			end
			queue_frame(fin, 3'($urandom), op, 1'($urandom), form, len, $urandom, -1);
		end
	endtask

	task automatic wait_drained();
		while (stream_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// sender
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (stream_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_byte <= stream_bytes.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver, with a long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			out_ready <= 1'b0;
			hold_count <= hold_count + 1;
			if (hold_count == HOLD_CYCLES - 1)
				hold_done <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		wsfp_pkg::wsfp_res_t want;
		wsfp_pkg::wsfp_res_t seen;
		bit produced;
		in_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				seen = '{data: out_byte, valid: payload_valid, last: frame_end,
					fin: final_fragment, opcode: frame_opcode, err: protocol_error};
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("unexpected item: byte %h pv %b end %b fin %b op %h err %b",
							seen.data, seen.valid, seen.last, seen.fin, seen.opcode, seen.err);
				end else begin
					want = expected_results.pop_front();
					if (seen.data !== want.data || seen.valid !== want.valid ||
							seen.last !== want.last || seen.fin !== want.fin ||
							seen.opcode !== want.opcode || seen.err !== want.err) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT) begin
							$write("mismatch: expected byte %h pv %b end %b fin %b op %h err %b, ",
								want.data, want.valid, want.last, want.fin, want.opcode,
								want.err);
							$display("got byte %h pv %b end %b fin %b op %h err %b",
								seen.data, seen.valid, seen.last, seen.fin,
								seen.opcode, seen.err);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				parse_byte(in_byte, produced, want);
				if (produced)
					expected_results.insert(expected_results.size(), want);
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// empty unmasked frame, empty masked continuation, masked payload of ones,
		// empty frame in 16-bit form, one zero byte in 64-bit form
		queue_frame(1'b1, 3'b000, 4'h1, 1'b0, LEN_SHORT, 0, 32'h0, -1);
		queue_frame(1'b0, 3'b111, 4'h0, 1'b1, LEN_SHORT, 0, 32'hFFFF_FFFF, -1);
		queue_frame(1'b1, 3'b010, 4'hF, 1'b1, LEN_SHORT, 2, 32'h0F5A_C381, 8'hFF);
		queue_frame(1'b1, 3'b101, 4'h2, 1'b0, LEN_EXT16, 0, 32'h0, -1);
		queue_frame(1'b1, 3'b000, 4'h8, 1'b0, LEN_EXT64, 1, 32'h0, 8'h00);
		wait_drained();

		send_idle_pct = 36;
		recv_idle_pct = 50;
		queue_random_frames(550);
		wait_drained();

		send_idle_pct = 50;
		recv_idle_pct = 36;
		queue_random_frames(550);
		wait_drained();

		// no idling; receiver stalls long enough for the input to back up
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_frames(300);
		hold_req = 1'b1;
		while (!hold_done)
			@(posedge clk);
		hold_req = 1'b0;
		queue_random_frames(250);
		wait_drained();

		// bad header: fin clear with a nonzero opcode, then the parser stays halted
		push_byte(8'h71);
		for (int i = 0; i < 6; i++)
			push_byte(8'($urandom));
		wait_drained();

		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
